FILE: rtl/core/gsr_pkg.sv
package gsr_pkg;

   localparam int VALUE_WIDTH    = 64;
   localparam int PORT_WIDTH     = 64;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 64;
   localparam int LATENCY        = VALUE_WIDTH + 3;

   localparam logic CSR_IDX_SPACING = 1'b0;

   typedef logic [VALUE_WIDTH-1:0] value_type;

   localparam value_type VW_SIGN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam value_type VW_MAX  = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

   typedef struct packed {
      logic      valid;
      logic      neg;
      value_type mag;
      value_type rem;
   } div_stage_type;

   function automatic value_type sat_abs(value_type v);
      value_type r;
      if (v == VW_SIGN) begin
         r = VW_MAX;
      end else if (v[VALUE_WIDTH-1]) begin
         r = value_type'(~v + value_type'(1));
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/gsr_cell.sv
module gsr_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  gsr_pkg::value_type     grid,
   input  gsr_pkg::div_stage_type stage_in,
   input  logic                   dividend_bit,
   output gsr_pkg::div_stage_type stage_out
);

   localparam int VW = gsr_pkg::VALUE_WIDTH;

   logic               valid_ff;
   logic               neg_ff;
   gsr_pkg::value_type mag_ff;
   gsr_pkg::value_type rem_ff;
   gsr_pkg::value_type rem_in;
   gsr_pkg::value_type trial;
   logic [VW:0]        diff;

   // remainder stays below grid, so its top bit is zero and can be shifted out
   always_comb begin
      trial  = {stage_in.rem[VW-2:0], dividend_bit};
      diff   = {1'b0, trial} - {1'b0, grid};
      rem_in = diff[VW] ? trial : diff[VW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= stage_in.neg;
      mag_ff <= stage_in.mag;
      rem_ff <= rem_in;
   end

   assign stage_out = '{valid: valid_ff, neg: neg_ff, mag: mag_ff, rem: rem_ff};

   a_rem_below_grid: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && grid != '0) |-> (rem_ff < grid))
      else $error("partial remainder not below grid");

   a_valid_follows: assert property (@(posedge clock) disable iff (reset)
      stage_in.valid |=> valid_ff)
      else $error("request lost in divider cell");

   a_mag_carried: assert property (@(posedge clock) disable iff (reset)
      stage_in.valid |=> (mag_ff == $past(stage_in.mag)))
      else $error("magnitude corrupted in divider cell");

endmodule

FILE: rtl/core/gsr_round.sv
module gsr_round (
   input  logic                                   clock,
   input  logic                                   reset,
   input  gsr_pkg::value_type                     grid,
   input  logic                                   grid_zero,
   input  gsr_pkg::div_stage_type                 stage_in,
   output logic                                   out_valid,
   output logic [gsr_pkg::VALUE_WIDTH-1:0]        out_value
);

   localparam int VW = gsr_pkg::VALUE_WIDTH;

   // stage A: remainder terms
   logic               a_valid_ff;
   logic               a_neg_ff;
   logic               a_bypass_ff;
   logic               a_up_ff;
   gsr_pkg::value_type a_mag_ff;
   gsr_pkg::value_type a_down_ff;
   gsr_pkg::value_type a_gap_ff;
   logic               a_up_in;
   gsr_pkg::value_type a_down_in;
   gsr_pkg::value_type a_gap_in;

   // stage B: choose rounded magnitude
   logic               b_valid_ff;
   logic               b_neg_ff;
   gsr_pkg::value_type b_mag_ff;
   gsr_pkg::value_type b_mag_in;
   logic [VW:0]        b_up;
   logic [VW:0]        b_limit;

   // stage C: restore sign
   logic               c_valid_ff;
   gsr_pkg::value_type c_value_ff;
   gsr_pkg::value_type c_value_in;

   always_comb begin
      a_up_in   = stage_in.rem > (grid >> 1);
      a_down_in = stage_in.mag - stage_in.rem;
      a_gap_in  = grid - stage_in.rem;
   end

   always_comb begin
      b_up    = {1'b0, a_mag_ff} + {1'b0, a_gap_ff};
      b_limit = a_neg_ff ? {1'b0, gsr_pkg::VW_SIGN} : {1'b0, gsr_pkg::VW_MAX};
      if (a_bypass_ff) begin
         b_mag_in = a_mag_ff;
      end else if (a_up_ff && b_up <= b_limit) begin
         b_mag_in = b_up[VW-1:0];
      end else begin
         b_mag_in = a_down_ff;
      end
   end

   always_comb begin
      c_value_in = b_neg_ff ? gsr_pkg::value_type'(~b_mag_ff + gsr_pkg::value_type'(1))
                            : b_mag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= stage_in.valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_neg_ff    <= stage_in.neg;
      a_bypass_ff <= grid_zero;
      a_up_ff     <= a_up_in;
      a_mag_ff    <= stage_in.mag;
      a_down_ff   <= a_down_in;
      a_gap_ff    <= a_gap_in;
      b_neg_ff    <= a_neg_ff;
      b_mag_ff    <= b_mag_in;
      c_value_ff  <= c_value_in;
   end

   assign out_valid = c_valid_ff;
   assign out_value = c_value_ff;

   a_mag_in_range: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && !b_neg_ff) |-> (b_mag_ff <= gsr_pkg::VW_MAX))
      else $error("positive result out of range");

   a_mag_not_grown: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !a_bypass_ff && !a_up_ff) |=> (b_mag_ff <= $past(a_mag_ff)))
      else $error("round toward zero grew magnitude");

   a_valid_chain: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff |=> ##1 c_valid_ff)
      else $error("request lost in rounding stages");

endmodule

FILE: rtl/core/grid_snap_rounder.sv
// grid_snap_rounder
// Pipeline: a request accepted by start reaches the result strobe rsp_valid after passing through
//   one input stage, one restoring divider cell per value bit, and three rounding stages.
// Throughput: one request per cycle; busy is high only while reset is asserted.
// Reset: synchronous active-high; clears the pipeline valid bits and the spacing register to 0.
// The receiver cannot stall: every result is presented for exactly one cycle.
module grid_snap_rounder (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [gsr_pkg::PORT_WIDTH-1:0]       req_coord_value,
   output logic                                 rsp_valid,
   output logic [gsr_pkg::PORT_WIDTH-1:0]       rsp_snapped_value,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [gsr_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [gsr_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [gsr_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   localparam int VW = gsr_pkg::VALUE_WIDTH;
   localparam int PW = gsr_pkg::PORT_WIDTH;

   logic [gsr_pkg::CSR_DATA_WIDTH-1:0] spacing_ff;
   logic [gsr_pkg::CSR_DATA_WIDTH-1:0] spacing_in;
   gsr_pkg::value_type                 grid_ff;
   gsr_pkg::value_type                 grid_in;
   logic                               grid_zero_ff;
   logic                               csr_write;
   logic                               csr_hit;

   gsr_pkg::div_stage_type             chain [VW+1];
   gsr_pkg::div_stage_type             entry_ff;
   gsr_pkg::div_stage_type             entry_in;
   gsr_pkg::value_type                 coord;
   logic                               accept;

   logic                               round_valid;
   gsr_pkg::value_type                 round_value;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_hit    = csr_paddr[3] == gsr_pkg::CSR_IDX_SPACING;

   always_comb begin
      spacing_in = spacing_ff;
      grid_in    = grid_ff;
      if (csr_write && csr_hit) begin
         spacing_in = csr_pwdata;
         grid_in    = gsr_pkg::sat_abs(csr_pwdata[VW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff   <= '0;
         grid_ff      <= '0;
         grid_zero_ff <= 1'b1;
      end else begin
         spacing_ff   <= spacing_in;
         grid_ff      <= grid_in;
         grid_zero_ff <= grid_in == '0;
      end
   end

   assign csr_prdata = csr_hit ? spacing_ff : '0;

   // input stage: split into sign and magnitude
   assign busy   = reset;
   assign accept = start && !busy;
   assign coord  = req_coord_value[VW-1:0];

   always_comb begin
      entry_in.valid = accept;
      entry_in.neg   = coord[VW-1];
      entry_in.mag   = coord[VW-1] ? gsr_pkg::value_type'(~coord + gsr_pkg::value_type'(1))
                                   : coord;
      entry_in.rem   = '0;
   end

   always_ff @(posedge clock) begin
      entry_ff.neg <= entry_in.neg;
      entry_ff.mag <= entry_in.mag;
      entry_ff.rem <= entry_in.rem;
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
   end

   assign chain[0] = entry_ff;

   // one restoring division step per cell, most significant dividend bit first
   for (genvar k = 0; k < VW; k++) begin : g_cell
      gsr_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .grid         (grid_ff),
         .stage_in     (chain[k]),
         .dividend_bit (chain[k].mag[VW-1-k]),
         .stage_out    (chain[k+1])
      );
   end

   gsr_round u_round (
      .clock     (clock),
      .reset     (reset),
      .grid      (grid_ff),
      .grid_zero (grid_zero_ff),
      .stage_in  (chain[VW]),
      .out_valid (round_valid),
      .out_value (round_value)
   );

   assign rsp_valid         = round_valid;
   assign rsp_snapped_value = {{(PW-VW+1){round_value[VW-1]}}, round_value[VW-2:0]};

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, gsr_pkg::LATENCY + 1))
      else $error("result without matching request");

   a_grid_abs: assert property (@(posedge clock) disable iff (reset)
      !grid_ff[VW-1])
      else $error("grid magnitude has sign bit set");

   a_grid_zero: assert property (@(posedge clock) disable iff (reset)
      grid_zero_ff == (grid_ff == '0))
      else $error("zero-grid flag out of step");

endmodule
